// ----- sv/bftk_pkg.sv -----
// Shared types and constants for the top-k box filter.
// Used by every module of the block; depends on nothing else.
package bftk_pkg;

   // Number of boxes held in the sorted list
   localparam int KEEP_LIMIT = 8;
   localparam int CNT_W      = $clog2(KEEP_LIMIT + 1);
   localparam int IDX_W      = (KEEP_LIMIT > 1) ? $clog2(KEEP_LIMIT) : 1;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int COORD_W = 15;
   localparam int AREA_W  = 2 * COORD_W;
   localparam int IN_W    = 16;
   localparam int REQ_DATA_W = 5 * IN_W;
   localparam int RSP_DATA_W = 64;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register reset values
   localparam logic [6:0]         MIN_CONF_RESET  = 7'd90;
   localparam logic [COORD_W-1:0] MIN_SIZE_RESET  = 15'd72;
   localparam logic [COORD_W-1:0] FRAME_W_RESET   = 15'd1920;
   localparam logic [COORD_W-1:0] FRAME_H_RESET   = 15'd1080;

   // Register indexes
   typedef enum logic [1:0] {
      REG_MIN_CONF = 2'd0,
      REG_MIN_SIZE = 2'd1,
      REG_FRAME_W  = 2'd2,
      REG_FRAME_H  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [6:0]         min_conf;
      logic [COORD_W-1:0] min_size;
      logic [COORD_W-1:0] frame_w;
      logic [COORD_W-1:0] frame_h;
   } cfg_type;

   // Clipped box, x in the lowest bits
   typedef struct packed {
      logic [COORD_W-1:0] h;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } box_type;

   // One classified candidate travelling to the back part
   typedef struct packed {
      logic              box_ok;
      logic              last;
      box_type           box;
      logic [AREA_W-1:0] area;
   } cand_type;

   typedef enum logic {
      ST_COLLECT = 1'b0,
      ST_EMIT    = 1'b1
   } back_state_type;

   typedef struct packed {
      logic             emitting;
      logic [CNT_W-1:0] kept_count;
   } back_status_type;

endpackage

// ----- sv/bftk_front.sv -----
// Front part: filters and clips incoming boxes and computes the clipped area.
// Depends on bftk_pkg; feeds bftk_queue.
module bftk_front (
   input  logic                                clock,
   input  logic                                reset,
   input  bftk_pkg::cfg_type                   cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bftk_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   output logic                                push_valid,
   output bftk_pkg::cand_type                  push_data,
   input  logic                                push_ready
);

   typedef struct packed {
      logic              box_ok;
      logic              last;
      bftk_pkg::box_type box;
   } clip_type;

   logic signed [15:0] conf, bx, by, bw, bh;
   logic signed [16:0] x0, y0, x1, y1, x1_sum, y1_sum, fw_s, fh_s;
   logic               pass, nonempty;
   logic [16:0]        cw, ch;
   clip_type           clip;
   logic               s1_valid_ff, s1_valid_in;
   clip_type           s1_ff;
   logic               s1_needed, s1_done;

   // Unpack the request fields
   assign conf = req_tdata[15:0];
   assign bx   = req_tdata[31:16];
   assign by   = req_tdata[47:32];
   assign bw   = req_tdata[63:48];
   assign bh   = req_tdata[79:64];

   // Threshold and clip
   always_comb begin
      pass = (conf >= $signed({9'd0, cfg.min_conf})) &&
             (bw >= $signed({1'b0, cfg.min_size})) &&
             (bh >= $signed({1'b0, cfg.min_size}));
      x0     = bx[15] ? 17'sd0 : {bx[15], bx};
      y0     = by[15] ? 17'sd0 : {by[15], by};
      x1_sum = {bx[15], bx} + {bw[15], bw};
      y1_sum = {by[15], by} + {bh[15], bh};
      fw_s   = $signed({2'b00, cfg.frame_w});
      fh_s   = $signed({2'b00, cfg.frame_h});
      x1     = (x1_sum > fw_s) ? fw_s : x1_sum;
      y1     = (y1_sum > fh_s) ? fh_s : y1_sum;
      nonempty = (x1 > x0) && (y1 > y0);
      cw = x1 - x0;
      ch = y1 - y0;
      clip.box_ok = pass && nonempty;
      clip.last   = req_tlast;
      clip.box.x  = x0[bftk_pkg::COORD_W-1:0];
      clip.box.y  = y0[bftk_pkg::COORD_W-1:0];
      clip.box.w  = cw[bftk_pkg::COORD_W-1:0];
      clip.box.h  = ch[bftk_pkg::COORD_W-1:0];
   end

   // Drop a stage that carries neither a box nor the end of a frame
   assign s1_needed  = s1_ff.box_ok || s1_ff.last;
   assign s1_done    = s1_valid_ff && (push_ready || !s1_needed);
   assign req_tready = !s1_valid_ff || s1_done;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s1_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_ff <= clip;
      end
   end

   // Area multiply on the registered box
   always_comb begin
      push_valid       = s1_valid_ff && s1_needed;
      push_data.box_ok = s1_ff.box_ok;
      push_data.last   = s1_ff.last;
      push_data.box    = s1_ff.box;
      push_data.area   = bftk_pkg::AREA_W'(s1_ff.box.w) * bftk_pkg::AREA_W'(s1_ff.box.h);
   end

endmodule

// ----- sv/bftk_queue.sv -----
// Short queue of classified candidates between front and back parts.
// Depends on bftk_pkg.
module bftk_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  bftk_pkg::cand_type push_data,
   output logic               push_ready,
   output logic               pop_valid,
   output bftk_pkg::cand_type pop_data,
   input  logic               pop_ready
);

   bftk_pkg::cand_type                slot_ff [bftk_pkg::QUEUE_DEPTH];
   logic [bftk_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [bftk_pkg::QCNT_W-1:0]       fill_ff, fill_in;
   logic                              do_push, do_pop;

   assign push_ready = (fill_ff != bftk_pkg::QCNT_W'(bftk_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == bftk_pkg::QPTR_W'(bftk_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == bftk_pkg::QPTR_W'(bftk_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/bftk_back.sv -----
// Back part: sorted insertion list of kept boxes and the result emitter.
// Depends on bftk_pkg; fed by bftk_queue.
module bftk_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             pop_valid,
   input  bftk_pkg::cand_type               pop_data,
   output logic                             pop_ready,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bftk_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   output bftk_pkg::back_status_type        status
);

   localparam int KL = bftk_pkg::KEEP_LIMIT;

   bftk_pkg::back_state_type          state_ff, state_in;
   bftk_pkg::box_type                 box_ff [KL];
   bftk_pkg::box_type                 box_in [KL];
   logic [bftk_pkg::AREA_W-1:0]       area_ff [KL];
   logic [bftk_pkg::AREA_W-1:0]       area_in [KL];
   logic [KL-1:0]                     ge;
   logic [bftk_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [bftk_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bftk_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              do_insert, out_free, at_end;
   bftk_pkg::box_type                 sel_box;

   assign pop_ready = (state_ff == bftk_pkg::ST_COLLECT);
   assign do_insert = pop_valid && pop_ready && pop_data.box_ok;
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Shift-insert: each cell keeps, takes the new box or takes its neighbor
   always_comb begin
      for (int i = 0; i < KL; i++) begin
         ge[i] = (bftk_pkg::CNT_W'(i) < count_ff) && (area_ff[i] >= pop_data.area);
      end
      for (int i = 0; i < KL; i++) begin
         box_in[i]  = box_ff[i];
         area_in[i] = area_ff[i];
         if (do_insert && !ge[i]) begin
            if (i == 0) begin
               box_in[i]  = pop_data.box;
               area_in[i] = pop_data.area;
            end else if (ge[i-1]) begin
               box_in[i]  = pop_data.box;
               area_in[i] = pop_data.area;
            end else begin
               box_in[i]  = box_ff[i-1];
               area_in[i] = area_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < KL; i++) begin
         box_ff[i]  <= box_in[i];
         area_ff[i] <= area_in[i];
      end
   end

   assign sel_box = box_ff[idx_ff];
   assign at_end  = (count_ff == '0) ||
                    (bftk_pkg::CNT_W'(idx_ff) + bftk_pkg::CNT_W'(1) == count_ff);

   // Sequence collect and emit
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         bftk_pkg::ST_COLLECT: begin
            if (do_insert && count_ff != bftk_pkg::CNT_W'(KL)) begin
               count_in = count_ff + 1'b1;
            end
            if (pop_valid && pop_data.last) begin
               state_in = bftk_pkg::ST_EMIT;
               idx_in   = '0;
            end
         end
         bftk_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = at_end;
               if (count_ff == '0) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in = {3'b000, sel_box, 1'b1};
               end
               idx_in = idx_ff + 1'b1;
               if (at_end) begin
                  state_in = bftk_pkg::ST_COLLECT;
                  count_in = '0;
               end
            end
         end
         default: begin
            state_in = bftk_pkg::ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bftk_pkg::ST_COLLECT;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign status.emitting   = (state_ff == bftk_pkg::ST_EMIT);
   assign status.kept_count = count_ff;

endmodule

// ----- sv/box_filter_top_k_by_area.sv -----
// Top-k box filter by area: throughput one candidate per cycle while collecting.
// An accepted candidate passes the front register and the queue before it enters the
// sorted list; after the final candidate the back part enters its emit state and offers
// one result per cycle from its result register while rsp_tready is high (up to
// KEEP_LIMIT), while the emit run holds the queue. Synchronous reset clears the list
// count, queue and handshakes, and restores the register defaults; kept boxes are not cleared.
module box_filter_top_k_by_area (
   input  logic                                 clock,
   input  logic                                 reset,
   // APB-style configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bftk_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [bftk_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bftk_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   // Candidate stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // confidence[15:0], box_x[31:16], box_y[47:32], box_width[63:48], box_height[79:64]
   input  logic [bftk_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tlast,       // final_candidate
   // Result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // valid_res[0], out_x[15:1], out_y[30:16], out_width[45:31], out_height[60:46],
   // zero[63:61]
   output logic [bftk_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast        // end_of_list
);

   bftk_pkg::cfg_type          cfg_ff, cfg_in;
   bftk_pkg::csr_index_type    csr_index;
   logic                       csr_write;
   logic                       push_valid, push_ready, pop_valid, pop_ready;
   bftk_pkg::cand_type         push_data, pop_data;
   bftk_pkg::back_status_type  back_status;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_index  = bftk_pkg::csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            bftk_pkg::REG_MIN_CONF: cfg_in.min_conf = csr_pwdata[6:0];
            bftk_pkg::REG_MIN_SIZE: cfg_in.min_size = csr_pwdata[14:0];
            bftk_pkg::REG_FRAME_W:  cfg_in.frame_w  = csr_pwdata[14:0];
            bftk_pkg::REG_FRAME_H:  cfg_in.frame_h  = csr_pwdata[14:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         bftk_pkg::REG_MIN_CONF: csr_prdata = {25'd0, cfg_ff.min_conf};
         bftk_pkg::REG_MIN_SIZE: csr_prdata = {17'd0, cfg_ff.min_size};
         bftk_pkg::REG_FRAME_W:  csr_prdata = {17'd0, cfg_ff.frame_w};
         bftk_pkg::REG_FRAME_H:  csr_prdata = {17'd0, cfg_ff.frame_h};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_conf <= bftk_pkg::MIN_CONF_RESET;
         cfg_ff.min_size <= bftk_pkg::MIN_SIZE_RESET;
         cfg_ff.frame_w  <= bftk_pkg::FRAME_W_RESET;
         cfg_ff.frame_h  <= bftk_pkg::FRAME_H_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bftk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   bftk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   bftk_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .status     (back_status)
   );

`ifndef SYNTHESIS
   // An empty answer always closes its run
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> rsp_tlast)
      else $error("empty answer without end_of_list");

   // The list is never touched while it is being emitted
   a_no_pop_in_emit: assert property (@(posedge clock) disable iff (reset)
      !(back_status.emitting && pop_ready))
      else $error("queue popped during emit run");

   // The list never holds more than its limit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      back_status.kept_count <= bftk_pkg::CNT_W'(bftk_pkg::KEEP_LIMIT))
      else $error("kept count beyond limit");

   // No result is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for box_filter_top_k_by_area: a ranking model predicts each
// emitted box list and a monitor compares the result stream against it.
// Depends on bftk_pkg and the block's top module only.
module tb_top;
   import bftk_pkg::*;

   // One candidate box as carried on the request stream
   typedef struct {
      logic [IN_W-1:0] conf;
      logic [IN_W-1:0] bx;
      logic [IN_W-1:0] by;
      logic [IN_W-1:0] bw;
      logic [IN_W-1:0] bh;
      logic            last;
   } cand_item;

   // One emitted result
   typedef struct {
      logic               valid;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic               eol;
   } box_result;

   // Keeps the largest clipped boxes of the current frame and the boxes still owed
   class area_ranker;
      cfg_type           cfg;
      box_type           kept_box[KEEP_LIMIT];
      logic [AREA_W-1:0] kept_area[KEEP_LIMIT];
      int                kept_count;
      box_result         due_boxes[$];
      int                errors, requests, frames, results_seen, empty_answers, dropped;

      function new();
         cfg.min_conf = MIN_CONF_RESET;
         cfg.min_size = MIN_SIZE_RESET;
         cfg.frame_w  = FRAME_W_RESET;
         cfg.frame_h  = FRAME_H_RESET;
         kept_count   = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [31:0] value);
         case (idx)
            REG_MIN_CONF: cfg.min_conf = value[6:0];
            REG_MIN_SIZE: cfg.min_size = value[COORD_W-1:0];
            REG_FRAME_W:  cfg.frame_w  = value[COORD_W-1:0];
            REG_FRAME_H:  cfg.frame_h  = value[COORD_W-1:0];
            default: ;
         endcase
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      // Filter, clip and rank one accepted request; on the frame's last box owe the list
      function void note_request(cand_item c);
         int                conf, bx, by, bw, bh, x0, y0, x1, y1, pos, top;
         box_type           b;
         logic [AREA_W-1:0] area;
         box_result         r;
         conf = int'($signed(c.conf));
         bx   = int'($signed(c.bx));
         by   = int'($signed(c.by));
         bw   = int'($signed(c.bw));
         bh   = int'($signed(c.bh));
         requests++;
         if (conf >= int'(cfg.min_conf) && bw >= int'(cfg.min_size) &&
             bh >= int'(cfg.min_size)) begin
            x0 = (bx > 0) ? bx : 0;
            y0 = (by > 0) ? by : 0;
            x1 = bx + bw;
            y1 = by + bh;
            if (x1 > int'(cfg.frame_w)) x1 = int'(cfg.frame_w);
            if (y1 > int'(cfg.frame_h)) y1 = int'(cfg.frame_h);
            if (x1 > x0 && y1 > y0) begin
               b.x  = x0[COORD_W-1:0];
               b.y  = y0[COORD_W-1:0];
               b.w  = COORD_W'(x1 - x0);
               b.h  = COORD_W'(y1 - y0);
               area = AREA_W'((x1 - x0) * (y1 - y0));
               // Equal areas stay in arrival order; a full list drops a box no larger
               pos = 0;
               while (pos < kept_count && kept_area[pos] >= area) pos++;
               if (pos < KEEP_LIMIT) begin
                  top = (kept_count < KEEP_LIMIT) ? kept_count : KEEP_LIMIT - 1;
                  for (int i = top; i > pos; i--) begin
                     kept_box[i]  = kept_box[i-1];
                     kept_area[i] = kept_area[i-1];
                  end
                  kept_box[pos]  = b;
                  kept_area[pos] = area;
                  if (kept_count < KEEP_LIMIT) kept_count++;
               end
            end else begin
               dropped++;
            end
         end else begin
            dropped++;
         end
         if (c.last) begin
            frames++;
            if (kept_count == 0) begin
               r.valid = 1'b0;
               r.x = '0; r.y = '0; r.w = '0; r.h = '0;
               r.eol = 1'b1;
               due_boxes = {due_boxes, r};
               empty_answers++;
            end else begin
               for (int k = 0; k < kept_count; k++) begin
                  r.valid = 1'b1;
                  r.x     = kept_box[k].x;
                  r.y     = kept_box[k].y;
                  r.w     = kept_box[k].w;
                  r.h     = kept_box[k].h;
                  r.eol   = (k == kept_count - 1);
                  due_boxes = {due_boxes, r};
               end
            end
            kept_count = 0;
         end
      endfunction

      task check_field(string name, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
         if (got !== want)
            report($sformatf("result %0d %s: got %0d, want %0d", results_seen, name, got, want));
      endtask

      // Compare an accepted result with the oldest box owed
      task check_response(box_result got);
         box_result want;
         results_seen++;
         if (due_boxes.size() == 0) begin
            report($sformatf("result %0d arrived with nothing owed (x=%0d y=%0d)",
                             results_seen, got.x, got.y));
            return;
         end
         want = due_boxes.pop_front();
         check_field("valid_res", COORD_W'(got.valid), COORD_W'(want.valid));
         check_field("out_x", got.x, want.x);
         check_field("out_y", got.y, want.y);
         check_field("out_width", got.w, want.w);
         check_field("out_height", got.h, want.h);
         check_field("end_of_list", COORD_W'(got.eol), COORD_W'(want.eol));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   logic                  req_tvalid, req_tready, req_tlast;
   // confidence, box_x, box_y, box_width, box_height (16 bits each, lowest first)
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid, rsp_tready, rsp_tlast;
   // valid_res, out_x, out_y, out_width, out_height, zero fill (lowest first)
   logic [RSP_DATA_W-1:0] rsp_tdata;

   area_ranker ranker = new();
   bit         steady;
   int         stall_left;
   int         settings_used;
   box_result  seen;

   box_filter_top_k_by_area dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short idles, now and then a long one; none in steady stretches
   function automatic int pick_idle(int long_lo, int long_hi);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 62) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(long_lo, long_hi);
   endfunction

   // Drive result backpressure
   always @(negedge clock) begin
      if (steady || stall_left == 0) begin
         rsp_tready <= 1'b1;
         stall_left <= pick_idle(10, 30);
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.valid = rsp_tdata[0];
         seen.x     = rsp_tdata[15:1];
         seen.y     = rsp_tdata[30:16];
         seen.w     = rsp_tdata[45:31];
         seen.h     = rsp_tdata[60:46];
         seen.eol   = rsp_tlast;
         ranker.check_response(seen);
      end
   end

   function automatic cand_item make_item(int conf, int x, int y, int w, int h, bit last);
      cand_item c;
      c.conf = IN_W'(conf);
      c.bx   = IN_W'(x);
      c.by   = IN_W'(y);
      c.bw   = IN_W'(w);
      c.bh   = IN_W'(h);
      c.last = last;
      return c;
   endfunction

   // Mostly boxes shaped to pass the filters, the rest raw noise
   function automatic cand_item random_candidate(bit last);
      cand_item c;
      int       mc, ms, fw, fh, conf, x, y, w, h;
      if ($urandom_range(0, 4) == 0) begin
         c.conf = IN_W'($urandom);
         c.bx   = IN_W'($urandom);
         c.by   = IN_W'($urandom);
         c.bw   = IN_W'($urandom);
         c.bh   = IN_W'($urandom);
         c.last = last;
         return c;
      end
      mc   = int'(ranker.cfg.min_conf);
      ms   = int'(ranker.cfg.min_size);
      fw   = int'(ranker.cfg.frame_w);
      fh   = int'(ranker.cfg.frame_h);
      conf = ($urandom_range(0, 9) == 0) ? mc - 1 : int'($urandom_range(mc, 100));
      x    = int'($urandom_range(0, fw + 128)) - 64;
      y    = int'($urandom_range(0, fh + 128)) - 64;
      if ($urandom_range(0, 4) == 0) begin
         // near-equal sizes so that area ties are common
         w = ms + int'($urandom_range(1, 2));
         h = ms + int'($urandom_range(1, 2));
      end else begin
         w = ms + int'($urandom_range(0, fw / 3 + 8));
         h = ms + int'($urandom_range(0, fh / 3 + 8));
      end
      if ($urandom_range(0, 9) == 0) w = ms - 1;
      if ($urandom_range(0, 9) == 0) h = ms - 1;
      return make_item(conf, x, y, w, h, last);
   endfunction

   // Present one request and hold it until accepted
   task automatic send_candidate(cand_item c);
      int gap;
      gap = pick_idle(8, 40);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {c.bh, c.bw, c.by, c.bx, c.conf};
      req_tlast  <= c.last;
      do @(posedge clock); while (!req_tready);
      ranker.note_request(c);
      @(negedge clock);
   endtask

   // Hold off requests until every owed result has come
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (ranker.due_boxes.size() != 0);
   endtask

   // Write one register, then read it back
   task automatic write_register(csr_index_type idx, logic [31:0] value);
      logic [31:0] mask;
      mask        = (idx == REG_MIN_CONF) ? 32'h7F : 32'h7FFF;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      ranker.set_register(idx, value);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== (value & mask))
         ranker.report($sformatf("register %s read %0h, want %0h", idx.name(), csr_prdata,
                                 value & mask));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Change settings only once the block is idle
   task automatic apply_settings(int conf, int size, int fw, int fh);
      wait_drained();
      repeat (8) @(negedge clock);
      write_register(REG_MIN_CONF, conf);
      write_register(REG_MIN_SIZE, size);
      write_register(REG_FRAME_W, fw);
      write_register(REG_FRAME_H, fh);
      settings_used++;
   endtask

   // Stimulus
   initial begin : stimulus
      int conf_v, size_v, fw_v, fh_v, sent, len;
      reset       = 1'b1;
      steady      = 1'b0;
      stall_left  = 0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: empty answer first
      send_candidate(make_item(0, 10, 10, 100, 100, 1));
      // Threshold edges, negative size, clipping, ties, full list
      send_candidate(make_item(90, 100, 100, 72, 72, 0));
      send_candidate(make_item(89, 100, 100, 72, 72, 0));
      send_candidate(make_item(100, 100, 100, 71, 100, 0));
      send_candidate(make_item(100, 100, 100, 100, -5, 0));
      send_candidate(make_item(32767, -100, -50, 300, 200, 0));
      send_candidate(make_item(95, 2000, 10, 100, 100, 0));
      send_candidate(make_item(95, 1800, 960, 200, 200, 0));
      send_candidate(make_item(95, 500, 500, 80, 90, 0));
      send_candidate(make_item(95, 600, 600, 90, 80, 0));
      send_candidate(make_item(-32768, 10, 10, 200, 200, 0));
      send_candidate(make_item(100, 32767, 32767, 32767, 32767, 0));
      send_candidate(make_item(100, -32768, -32768, 32767, 32767, 0));
      send_candidate(make_item(100, 0, 0, 1920, 1080, 0));
      send_candidate(make_item(100, 10, 10, 100, 100, 0));
      send_candidate(make_item(100, 20, 20, 200, 100, 0));
      send_candidate(make_item(100, 40, 40, 72, 72, 0));
      send_candidate(make_item(100, 50, 50, 73, 73, 1));
      send_candidate(make_item(100, 0, 0, 72, 72, 1));

      // Zero-width frame drops everything
      apply_settings(90, 72, 0, 1080);
      send_candidate(make_item(100, 0, 0, 200, 200, 0));
      send_candidate(make_item(100, 5, 5, 300, 300, 1));

      // Largest registers: only a full-frame box survives
      apply_settings(127, 32767, 32767, 32767);
      send_candidate(make_item(32767, 0, 0, 32767, 32767, 0));
      send_candidate(make_item(126, 0, 0, 32767, 32767, 1));

      // Smallest thresholds: zero size clips empty, one pixel is kept
      apply_settings(0, 0, 1920, 1080);
      send_candidate(make_item(0, 5, 5, 0, 0, 0));
      send_candidate(make_item(0, 5, 5, 1, 1, 1));

      // Random frames under a series of settings
      for (int p = 0; p < 9; p++) begin
         case (p)
            0: begin conf_v = 90;  size_v = 72; fw_v = 1920;  fh_v = 1080;  end
            1: begin conf_v = 0;   size_v = 0;  fw_v = 1;     fh_v = 1;     end
            2: begin conf_v = 127; size_v = 0;  fw_v = 32767; fh_v = 32767; end
            default: begin
               case ($urandom_range(0, 5))
                  0: conf_v = 0;
                  1: conf_v = 100;
                  2: conf_v = 127;
                  default: conf_v = $urandom_range(50, 100);
               endcase
               size_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1)
                                                    : $urandom_range(2, 80);
               case ($urandom_range(0, 5))
                  0: fw_v = 1;
                  1: fw_v = 32767;
                  default: fw_v = $urandom_range(32, 2000);
               endcase
               case ($urandom_range(0, 5))
                  0: fh_v = 1;
                  1: fh_v = 32767;
                  default: fh_v = $urandom_range(32, 2000);
               endcase
            end
         endcase
         apply_settings(conf_v, size_v, fw_v, fh_v);
         steady = (p % 3 == 1);
         sent   = 0;
         while (sent < 22) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            for (int k = 0; k < len; k++) send_candidate(random_candidate(k == len - 1));
            sent += len;
            // one phase waits out every frame before starting the next
            if (p == 4) wait_drained();
         end
      end
      steady = 1'b0;

      // Drain, then watch for strays
      req_tvalid <= 1'b0;
      for (int t = 0; t < 20000 && ranker.due_boxes.size() != 0; t++) @(posedge clock);
      repeat (30) @(posedge clock);
      if (ranker.due_boxes.size() != 0)
         ranker.report($sformatf("%0d results never arrived", ranker.due_boxes.size()));

      $display("Run: %0d candidates in %0d frames over %0d register settings, %0d results",
               ranker.requests, ranker.frames, settings_used + 1, ranker.results_seen);
      $display("     %0d empty answers, %0d candidates filtered or clipped away",
               ranker.empty_answers, ranker.dropped);
      if (ranker.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Hard stop if the block hangs
   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule
